@@ design/cse_pkg.sv @@
package cse_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 32;

  localparam int CNT_W    = 32;
  localparam int N_W      = 32;
  localparam int OUT_W    = 24;
  localparam int ACC_W    = 64;
  localparam int TCNT_W   = 40;
  localparam int LOG_W    = 5 + FRAC_BITS;
  localparam int LG_RAW_W = 35;
  localparam int LG_SHIFT = 30 - FRAC_BITS;
  localparam int IDX_W    = 5;
  localparam int IP_W     = 26;
  localparam int TAB_N    = 33;
  localparam int TAB_W    = 31;
  localparam int MUL_W    = 32 + LOG_W;
  localparam int SPLIT_W  = TCNT_W + LOG_W;
  localparam int DNUM_W   = (SPLIT_W > ACC_W) ? SPLIT_W : ACC_W;
  localparam int REM_W    = N_W + OUT_W;
  localparam int DCNT_W   = $clog2(OUT_W);

  localparam logic [OUT_W-1:0]  OUT_MAX  = '1;
  localparam logic [TCNT_W-1:0] TCNT_MAX = '1;

  typedef logic [TAB_N-1:0][TAB_W-1:0] log_tab_t;

  // log2(1 + i/32) in Q1.30 by repeated squaring
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] z;
    logic [29:0] r;
    t = '0;
    for (int i = 0; i < 32; i++) begin
      z = 64'(32 + i) << 26;
      r = '0;
      for (int b = 0; b < 30; b++) begin
        z = (z * z) >> 31;
        r = {r[28:0], 1'b0};
        if (z >= 64'h1_0000_0000) begin
          r[0] = 1'b1;
          z    = z >> 1;
        end
      end
      t[i] = {1'b0, r};
    end
    t[32] = 31'h4000_0000;
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  typedef enum logic [1:0] {
    PH_CELL,
    PH_ROW,
    PH_N
  } phase_t;

  typedef struct packed {
    logic   take_cell;
    phase_t src;
    logic   lg_norm;
    logic   lg_interp;
    logic   lg_sum;
    logic   mul_lo;
    logic   mul_hi;
    logic   acc_cell;
    logic   close_a;
    logic   close_b;
    logic   split_add;
    logic   split_sub;
    logic   div_load;
    logic   div_split;
    logic   div_step;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic row_nz;
  } dp_stat_t;

endpackage

@@ design/conditional_split_entropy.sv @@
// Scores one contingency table for a decision-tree split. Cells arrive one word
// at a time in row-major order with row_end and table_end marks; the word that
// carries table_end yields one result word with the conditional entropy and
// the split entropy, both unsigned Q8.16 and saturating. N is to be written through
// the configuration channel (reset value 1, zero acts as 1) while no table is
// in progress; the user must keep to this, as the block does not enforce it.
// Each cell uses the single shared log2 unit and multiplier; a cell closing a
// row with a nonzero total uses them again, and the table-end cell adds
// log2(N), the split product and two divisions, plus any wait for a previous
// result still held at the output. The divider retires one quotient bit per
// cycle. A new table may start while the last result waits.
module conditional_split_entropy (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cse_pkg::N_W-1:0]    n_total,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cse_pkg::CNT_W-1:0]  cell_count,
  input  logic                       row_end,
  input  logic                       table_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cse_pkg::OUT_W-1:0]  cond_entropy,
  output logic [cse_pkg::OUT_W-1:0]  split_entropy
);
  import cse_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .row_end   (row_end),
    .table_end (table_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cse_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (n_total),
    .cell_count    (cell_count),
    .cmd           (cmd),
    .stat          (stat),
    .cond_entropy  (cond_entropy),
    .split_entropy (split_entropy)
  );

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take_cell, cmd.lg_norm, cmd.lg_interp, cmd.lg_sum, cmd.mul_lo,
              cmd.mul_hi, cmd.acc_cell, cmd.close_a, cmd.close_b, cmd.split_add,
              cmd.split_sub, cmd.div_load, cmd.div_step, cmd.out_load}))
    else $error("datapath commands overlap");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while a word is in work");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not presented");

  a_rise_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result presented without a load");

endmodule

@@ design/cse_dp.sv @@
module cse_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cse_pkg::N_W-1:0]    cfg_data,
  input  logic [cse_pkg::CNT_W-1:0]  cell_count,
  input  cse_pkg::dp_cmd_t           cmd,
  output cse_pkg::dp_stat_t          stat,
  output logic [cse_pkg::OUT_W-1:0]  cond_entropy,
  output logic [cse_pkg::OUT_W-1:0]  split_entropy
);
  import cse_pkg::*;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  logic [N_W-1:0]        n_reg;
  logic [N_W-1:0]        n_eff;
  logic [COUNT_BITS-1:0] v_reg;
  logic [COUNT_BITS-1:0] row_sum;
  logic [ACC_W-1:0]      row_vlogv_sum;
  logic [ACC_W-1:0]      weighted_numerator;
  logic [TCNT_W-1:0]     table_count_sum;
  logic [ACC_W-1:0]      table_tlogt_sum;
  logic [ACC_W-1:0]      term;

  logic [31:0]           lg_x;
  logic [31:0]           nx;
  logic [IDX_W-1:0]      sh;
  logic [30:0]           nrm_m;
  logic [IDX_W-1:0]      nrm_e;
  logic                  nrm_z;
  logic [IDX_W-1:0]      idx;
  logic [TAB_W-1:0]      tab_lo;
  logic [TAB_W-1:0]      tab_hi;
  logic [TAB_W-1:0]      tab_diff;
  logic [TAB_W-1:0]      ip_lo;
  logic [2*IP_W-1:0]     ip_prod;
  logic [IDX_W-1:0]      ip_e;
  logic                  ip_z;
  logic [LG_RAW_W-1:0]   lg_raw;
  logic [LOG_W-1:0]      lg_val;

  logic [31:0]           mul_a;
  logic [MUL_W-1:0]      prod;
  logic [ACC_W-1:0]      tl;
  logic [COUNT_BITS:0]   row_next;
  logic [TCNT_W:0]       tcs_next;
  logic [SPLIT_W-1:0]    split_acc;
  logic [DNUM_W-1:0]     sub_a;
  logic [DNUM_W-1:0]     sub_b;

  logic [DNUM_W-1:0]     div_num;
  logic [REM_W-1:0]      rem;
  logic [REM_W-1:0]      dsh;
  logic [OUT_W-1:0]      quo;
  logic                  dsat;
  logic [OUT_W-1:0]      div_q;
  logic [OUT_W-1:0]      cond_q;

  assign n_eff       = (n_reg == '0) ? N_W'(1) : n_reg;
  assign stat.row_nz = (row_sum != '0);

  always_comb begin
    unique case (cmd.src)
      PH_CELL: lg_x = 32'(v_reg);
      PH_ROW:  lg_x = 32'(row_sum);
      PH_N:    lg_x = 32'(n_eff);
      default: lg_x = '0;
    endcase
  end

  always_comb begin
    nx = lg_x;
    sh = '0;
    if (nx[31:16] == '0) begin
      nx    = nx << 16;
      sh[4] = 1'b1;
    end
    if (nx[31:24] == '0) begin
      nx    = nx << 8;
      sh[3] = 1'b1;
    end
    if (nx[31:28] == '0) begin
      nx    = nx << 4;
      sh[2] = 1'b1;
    end
    if (nx[31:30] == '0) begin
      nx    = nx << 2;
      sh[1] = 1'b1;
    end
    if (!nx[31]) begin
      nx    = nx << 1;
      sh[0] = 1'b1;
    end
  end

  assign idx      = nrm_m[30 -: IDX_W];
  assign tab_lo   = LOG_TAB[{1'b0, idx}];
  assign tab_hi   = LOG_TAB[6'({1'b0, idx}) + 6'd1];
  assign tab_diff = tab_hi - tab_lo;
  assign lg_raw   = LG_RAW_W'({ip_e, 30'b0}) + LG_RAW_W'(ip_lo)
                  + LG_RAW_W'(ip_prod[2*IP_W-1 -: IP_W]);

  assign mul_a    = cmd.mul_hi ? 32'(table_count_sum[TCNT_W-1:32])
                  : (cmd.src == PH_N) ? table_count_sum[31:0] : lg_x;
  assign tl       = ACC_W'(prod);
  assign row_next = {1'b0, row_sum} + {1'b0, cell_count[COUNT_BITS-1:0]};
  assign tcs_next = {1'b0, table_count_sum} + (TCNT_W+1)'(row_sum);
  assign sub_a    = DNUM_W'(split_acc);
  assign sub_b    = DNUM_W'(table_tlogt_sum);
  assign div_num  = cmd.div_split ? DNUM_W'(split_acc) : DNUM_W'(weighted_numerator);
  assign div_q    = dsat ? OUT_MAX : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_reg              <= N_W'(1);
      row_sum            <= '0;
      row_vlogv_sum      <= '0;
      weighted_numerator <= '0;
      table_count_sum    <= '0;
      table_tlogt_sum    <= '0;
    end else begin
      if (cfg_we) begin
        n_reg <= cfg_data;
      end
      if (cmd.take_cell) begin
        v_reg   <= cell_count[COUNT_BITS-1:0];
        row_sum <= row_next[COUNT_BITS] ? '1 : row_next[COUNT_BITS-1:0];
      end
      if (cmd.lg_norm) begin
        nrm_m <= nx[30:0];
        nrm_e <= ~sh;
        nrm_z <= (lg_x == '0);
      end
      if (cmd.lg_interp) begin
        ip_lo   <= tab_lo;
        ip_prod <= tab_diff[IP_W-1:0] * nrm_m[IP_W-1:0];
        ip_e    <= nrm_e;
        ip_z    <= nrm_z;
      end
      if (cmd.lg_sum) begin
        lg_val <= ip_z ? '0 : lg_raw[LG_SHIFT +: LOG_W];
      end
      if (cmd.mul_lo || cmd.mul_hi) begin
        prod <= MUL_W'(mul_a) * MUL_W'(lg_val);
      end
      if (cmd.mul_hi) begin
        split_acc <= SPLIT_W'(prod);
      end
      if (cmd.acc_cell) begin
        row_vlogv_sum <= sat_add(row_vlogv_sum, tl);
      end
      if (cmd.close_a) begin
        term            <= (tl > row_vlogv_sum) ? tl - row_vlogv_sum : '0;
        table_count_sum <= tcs_next[TCNT_W] ? TCNT_MAX : tcs_next[TCNT_W-1:0];
        table_tlogt_sum <= sat_add(table_tlogt_sum, tl);
      end
      if (cmd.close_b) begin
        weighted_numerator <= sat_add(weighted_numerator, term);
        row_sum            <= '0;
        row_vlogv_sum      <= '0;
      end
      if (cmd.split_add) begin
        split_acc <= split_acc + (SPLIT_W'(prod) << 32);
      end
      if (cmd.split_sub) begin
        split_acc <= (sub_a > sub_b) ? SPLIT_W'(sub_a - sub_b) : '0;
      end
      if (cmd.div_load) begin
        dsat <= div_num >= (DNUM_W'(n_eff) << OUT_W);
        rem  <= div_num[REM_W-1:0];
        dsh  <= REM_W'(n_eff) << (OUT_W - 1);
        quo  <= '0;
        if (cmd.div_split) begin
          cond_q <= div_q;
        end
      end
      if (cmd.div_step) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[OUT_W-2:0], 1'b1};
        end else begin
          quo <= {quo[OUT_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      if (cmd.out_load) begin
        cond_entropy       <= cond_q;
        split_entropy      <= div_q;
        row_sum            <= '0;
        row_vlogv_sum      <= '0;
        weighted_numerator <= '0;
        table_count_sum    <= '0;
        table_tlogt_sum    <= '0;
      end
    end
  end

endmodule

@@ design/cse_ctrl.sv @@
module cse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               row_end,
  input  logic               table_end,
  output logic               out_valid,
  input  logic               out_stall,
  input  cse_pkg::dp_stat_t  stat,
  output cse_pkg::dp_cmd_t   cmd
);
  import cse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LNORM,
    S_LINTERP,
    S_LSUM,
    S_MUL,
    S_ACC,
    S_CLOSE_A,
    S_CLOSE_B,
    S_MUL_HI,
    S_SPLIT_ADD,
    S_SPLIT_SUB,
    S_DLOAD_C,
    S_DIV_C,
    S_DLOAD_S,
    S_DIV_S,
    S_DONE
  } state_t;

  state_t            state;
  phase_t            phase;
  logic              rclose;
  logic              tclose;
  logic [DCNT_W-1:0] dcnt;
  logic              out_free;
  logic              div_last;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign div_last = (dcnt == DCNT_W'(OUT_W - 1));

  always_comb begin
    cmd     = '0;
    cmd.src = phase;
    unique case (state)
      S_IDLE:      cmd.take_cell = in_valid;
      S_LNORM:     cmd.lg_norm   = 1'b1;
      S_LINTERP:   cmd.lg_interp = 1'b1;
      S_LSUM:      cmd.lg_sum    = 1'b1;
      S_MUL:       cmd.mul_lo    = 1'b1;
      S_ACC:       cmd.acc_cell  = 1'b1;
      S_CLOSE_A:   cmd.close_a   = 1'b1;
      S_CLOSE_B:   cmd.close_b   = 1'b1;
      S_MUL_HI:    cmd.mul_hi    = 1'b1;
      S_SPLIT_ADD: cmd.split_add = 1'b1;
      S_SPLIT_SUB: cmd.split_sub = 1'b1;
      S_DLOAD_C:   cmd.div_load  = 1'b1;
      S_DIV_C:     cmd.div_step  = 1'b1;
      S_DLOAD_S: begin
        cmd.div_load  = 1'b1;
        cmd.div_split = 1'b1;
      end
      S_DIV_S:     cmd.div_step  = 1'b1;
      S_DONE:      cmd.out_load  = out_free;
      default:     cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_CELL;
      rclose    <= 1'b0;
      tclose    <= 1'b0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rclose <= row_end || table_end;
            tclose <= table_end;
            phase  <= PH_CELL;
            state  <= S_LNORM;
          end
        end
        S_LNORM:   state <= S_LINTERP;
        S_LINTERP: state <= S_LSUM;
        S_LSUM:    state <= S_MUL;
        S_MUL: begin
          unique case (phase)
            PH_CELL: state <= S_ACC;
            PH_ROW:  state <= S_CLOSE_A;
            PH_N:    state <= S_MUL_HI;
            default: state <= S_IDLE;
          endcase
        end
        S_ACC: begin
          if (rclose && stat.row_nz) begin
            phase <= PH_ROW;
            state <= S_LNORM;
          end else if (tclose) begin
            phase <= PH_N;
            state <= S_LNORM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CLOSE_A: state <= S_CLOSE_B;
        S_CLOSE_B: begin
          if (tclose) begin
            phase <= PH_N;
            state <= S_LNORM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MUL_HI:    state <= S_SPLIT_ADD;
        S_SPLIT_ADD: state <= S_SPLIT_SUB;
        S_SPLIT_SUB: state <= S_DLOAD_C;
        S_DLOAD_C: begin
          dcnt  <= '0;
          state <= S_DIV_C;
        end
        S_DIV_C: begin
          dcnt <= dcnt + DCNT_W'(1);
          if (div_last) begin
            state <= S_DLOAD_S;
          end
        end
        S_DLOAD_S: begin
          dcnt  <= '0;
          state <= S_DIV_S;
        end
        S_DIV_S: begin
          dcnt <= dcnt + DCNT_W'(1);
          if (div_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_conditional_split_entropy.sv @@
`timescale 1ns / 100ps

module tb_conditional_split_entropy;
  import cse_pkg::*;

  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic             rend;
    logic             tend;
  } cell_word_t;

  typedef struct {
    logic [OUT_W-1:0] ce;
    logic [OUT_W-1:0] se;
  } score_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [N_W-1:0]   n_total = 32'd1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CNT_W-1:0] cell_count = '0;
  logic             row_end = 1'b0;
  logic             table_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] cond_entropy;
  logic [OUT_W-1:0] split_entropy;

  cell_word_t cell_q[$];
  score_t     score_q[$];

  logic [63:0] lg_lut [0:32];
  logic [31:0] divisor = 32'd1;
  logic [31:0] row_tot = '0;
  logic [63:0] row_vl = '0;
  logic [63:0] numer = '0;
  logic [39:0] tcnt = '0;
  logic [63:0] tlogt = '0;

  int idle_pct = 38;
  int errs = 0;
  int n_cells = 0;
  int n_scores = 0;
  int n_writes = 0;
  int pushed = 0;
  int quiet = 0;

  conditional_split_entropy i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .n_total         (n_total),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cell_count      (cell_count),
    .row_end         (row_end),
    .table_end       (table_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cond_entropy    (cond_entropy),
    .split_entropy   (split_entropy)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] lut_entry(input int i);
    logic [63:0] z;
    logic [63:0] bits;
    z = 64'(32 + i) << 26;
    bits = '0;
    if (i == 32) begin
      return 64'd1 << 30;
    end
    repeat (30) begin
      z = (z * z) >> 31;
      bits = bits << 1;
      if (z[63:32] != 0) begin
        bits[0] = 1'b1;
        z = z >> 1;
      end
    end
    return bits;
  endfunction

  function automatic logic [63:0] lg2(input logic [31:0] x);
    int          e;
    logic [31:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] frac;
    logic [63:0] v;
    if (x == 0) begin
      return '0;
    end
    e = 31;
    while (!x[e]) e--;
    m = x << (31 - e);
    lo = lg_lut[int'(m[30:26])];
    hi = lg_lut[int'(m[30:26]) + 1];
    frac = 64'(m[25:0]);
    v = (64'(e) << 30) + lo + (((hi - lo) * frac) >> 26);
    return v >> (30 - FRAC_BITS);
  endfunction

  function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = 65'(a) + 65'(b);
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [OUT_W-1:0] div_clip(input logic [127:0] num,
                                                input logic [31:0] d);
    logic [127:0] dd;
    logic [127:0] q;
    dd = 128'(d);
    q = num / dd;
    return (q > 128'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
  endfunction

  task automatic close_row();
    logic [63:0] rt;
    logic [63:0] tl;
    logic [63:0] term;
    logic [40:0] ts;
    if (row_tot != 0) begin
      rt = 64'(row_tot);
      tl = rt * lg2(row_tot);
      term = (tl > row_vl) ? tl - row_vl : '0;
      numer = sat64(numer, term);
      ts = 41'(tcnt) + 41'(row_tot);
      tcnt = ts[40] ? '1 : ts[39:0];
      tlogt = sat64(tlogt, tl);
      row_tot = '0;
      row_vl = '0;
    end
  endtask

  task automatic score_cell(input cell_word_t w);
    logic [32:0]  rs;
    logic [63:0]  cv;
    logic [31:0]  nd;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] prod;
    score_t       s;
    rs = 33'(row_tot) + 33'(w.count);
    row_tot = rs[32] ? '1 : rs[31:0];
    cv = 64'(w.count);
    row_vl = sat64(row_vl, cv * lg2(w.count));
    if (w.rend || w.tend) close_row();
    if (w.tend) begin
      nd = (divisor == 0) ? 32'd1 : divisor;
      a = 128'(numer);
      s.ce = div_clip(a, nd);
      a = 128'(tcnt);
      b = 128'(lg2(nd));
      prod = a * b;
      b = 128'(tlogt);
      prod = (prod < b) ? '0 : prod - b;
      s.se = div_clip(prod, nd);
      score_q.push_back(s);
      row_tot = '0;
      row_vl = '0;
      numer = '0;
      tcnt = '0;
      tlogt = '0;
    end
  endtask

  task automatic flag(input string what);
    errs++;
    if (errs <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : drv
    cell_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        w.count = cell_count;
        w.rend = row_end;
        w.tend = table_end;
        score_cell(w);
        n_cells++;
      end
      if (!in_valid || !in_stall) begin
        if (cell_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          w = cell_q.pop_front();
          in_valid <= 1'b1;
          cell_count <= w.count;
          row_end <= w.rend;
          table_end <= w.tend;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    score_t s;
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (score_q.size() == 0) begin
        flag($sformatf("unexpected result word cond=%h split=%h",
                       cond_entropy, split_entropy));
      end else begin
        s = score_q.pop_front();
        n_scores++;
        if (cond_entropy !== s.ce)
          flag($sformatf("cond_entropy %h, want %h", cond_entropy, s.ce));
        if (split_entropy !== s.se)
          flag($sformatf("split_entropy %h, want %h", split_entropy, s.se));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("tb_conditional_split_entropy: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic put(input logic [31:0] count, input logic re, input logic te);
    cell_word_t w;
    w.count = count;
    w.rend = re;
    w.tend = te;
    cell_q.push_back(w);
    pushed++;
  endtask

  task automatic drain();
    while (cell_q.size() != 0 || in_valid || score_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_divisor(input logic [31:0] v);
    drain();
    repeat (70) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    n_total <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    divisor = v;
    n_writes++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_count(input logic [31:0] scale);
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 14) return '1;
    if (r < 24) return $urandom;
    return $urandom_range(scale);
  endfunction

  task automatic push_table(input logic [31:0] scale);
    int   rows;
    int   cells;
    int   style;
    logic re;
    logic te;
    rows = $urandom_range(5, 1);
    style = $urandom_range(99);
    if (style < 5) rows = $urandom_range(12, 6);
    for (int r = 0; r < rows; r++) begin
      cells = $urandom_range(5, 1);
      for (int c = 0; c < cells; c++) begin
        re = (c == cells - 1);
        te = re && (r == rows - 1);
        if (style >= 90 && style < 96 && te) re = 1'b0;
        if (style >= 96) re = 1'($urandom_range(1));
        put(pick_count(scale), re, te);
      end
    end
  endtask

  initial begin
    logic [31:0] nlist [5];
    logic [31:0] scale;
    for (int i = 0; i < 33; i++) lg_lut[i] = lut_entry(i);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_divisor(32'd1000);
    put(32'd3, 1'b0, 1'b0);
    put(32'd5, 1'b1, 1'b0);
    put(32'd0, 1'b0, 1'b0);
    put(32'd0, 1'b1, 1'b0);
    put(32'd7, 1'b0, 1'b1);
    put(32'hFFFF_FFFF, 1'b0, 1'b0);
    put(32'hFFFF_FFFF, 1'b1, 1'b0);
    put(32'd1, 1'b1, 1'b1);
    put(32'd0, 1'b0, 1'b1);
    put(32'd1, 1'b1, 1'b0);
    put(32'd2, 1'b1, 1'b0);
    put(32'h8000_0000, 1'b0, 1'b0);
    put(32'h7FFF_FFFF, 1'b1, 1'b1);
    set_divisor(32'd0);
    put(32'd6, 1'b1, 1'b0);
    put(32'd2, 1'b0, 1'b1);
    set_divisor(32'd1);
    put(32'd100, 1'b0, 1'b0);
    put(32'd200, 1'b1, 1'b1);

    // saturate the table count with the handshakes held open
    set_divisor(32'hFFFF_FFFF);
    idle_pct = 0;
    for (int i = 0; i < 300; i++) put('1, 1'b1, i == 299);
    drain();
    idle_pct = 38;

    nlist[0] = $urandom_range(4000, 16);
    nlist[1] = 32'hFFFF_FFFF;
    nlist[2] = $urandom;
    nlist[3] = $urandom_range(300, 2);
    nlist[4] = 32'd1;
    foreach (nlist[k]) begin
      set_divisor(nlist[k]);
      scale = (nlist[k] >> 2) + 1;
      pushed = 0;
      while (pushed < 40) push_table(scale);
      drain();
      while (pushed < 80) push_table(scale);
    end

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d cell words over %0d scored tables, %0d divisor writes",
             n_cells, n_scores, n_writes);
    $display("incl. zero rows, open rows at table end, zero and max divisor, saturation");
    if (errs == 0) begin
      $display("tb_conditional_split_entropy: PASS");
    end else begin
      $display("tb_conditional_split_entropy: FAIL");
    end
    $finish;
  end

endmodule
